// ===== design/hbad_pkg.sv =====
package hbad_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int ACC_W      = 28;
  localparam int COEF_W     = 18;
  localparam int PROD_W     = COEF_W + 1 + ACC_W;
  localparam int MAX_STAGES = 3;
  localparam int SECTIONS   = 3;
  localparam int NUM_COEFS  = 2 * SECTIONS;
  localparam int MEM_DEPTH  = MAX_STAGES * NUM_COEFS;
  localparam int MEM_AW     = $clog2(MEM_DEPTH);
  localparam int STAGE_W    = $clog2(MAX_STAGES + 1);
  localparam int SECT_W     = $clog2(SECTIONS);
  localparam int COEF_IW    = $clog2(NUM_COEFS);
  localparam int CFG_IW     = 3;
  localparam int STEP_W     = 4;
  localparam int ROM_DEPTH  = 1 << STEP_W;

  typedef logic [CFG_IW-1:0]  cfg_index_t;
  typedef logic [STEP_W-1:0]  step_t;
  typedef logic [STAGE_W-1:0] stage_t;
  typedef logic [SECT_W-1:0]  sect_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  localparam cfg_index_t REG_STAGE_COUNT    = 3'd0;
  localparam cfg_index_t REG_DIRECT_COEF_A  = 3'd1;
  localparam cfg_index_t REG_DIRECT_COEF_B  = 3'd2;
  localparam cfg_index_t REG_DIRECT_COEF_C  = 3'd3;
  localparam cfg_index_t REG_DELAYED_COEF_A = 3'd4;
  localparam cfg_index_t REG_DELAYED_COEF_B = 3'd5;
  localparam cfg_index_t REG_DELAYED_COEF_C = 3'd6;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_DISPATCH,
    OP_MUL_IN,
    OP_ADD_MEM,
    OP_MUL_OUT,
    OP_SUB_MEM,
    OP_COMBINE,
    OP_EMIT
  } op_e;

  typedef struct packed {
    op_e   op;
    sect_t sect;
    step_t jmp;
  } ctrl_word_t;

  typedef struct packed {
    op_e    op;
    sect_t  sect;
    stage_t stage;
    logic   path;
  } ctrl_t;

  localparam step_t STEP_IDLE     = 4'd0;
  localparam step_t STEP_DISPATCH = 4'd1;
  localparam step_t STEP_COMBINE  = 4'd14;
  localparam step_t STEP_EMIT     = 4'd15;

  // microcode: each allpass section is mul, add, mul, sub on the shared multiplier
  localparam ctrl_word_t MICRO_ROM [ROM_DEPTH] = '{
    '{OP_IDLE,     2'd0, STEP_IDLE},
    '{OP_DISPATCH, 2'd0, STEP_EMIT},
    '{OP_MUL_IN,   2'd0, STEP_IDLE},
    '{OP_ADD_MEM,  2'd0, STEP_IDLE},
    '{OP_MUL_OUT,  2'd0, STEP_IDLE},
    '{OP_SUB_MEM,  2'd0, STEP_IDLE},
    '{OP_MUL_IN,   2'd1, STEP_IDLE},
    '{OP_ADD_MEM,  2'd1, STEP_IDLE},
    '{OP_MUL_OUT,  2'd1, STEP_IDLE},
    '{OP_SUB_MEM,  2'd1, STEP_IDLE},
    '{OP_MUL_IN,   2'd2, STEP_IDLE},
    '{OP_ADD_MEM,  2'd2, STEP_IDLE},
    '{OP_MUL_OUT,  2'd2, STEP_IDLE},
    '{OP_SUB_MEM,  2'd2, STEP_IDLE},
    '{OP_COMBINE,  2'd0, STEP_DISPATCH},
    '{OP_EMIT,     2'd0, STEP_IDLE}
  };

  function automatic acc_t sat_acc(input logic signed [ACC_W:0] v);
    acc_t r;
    if (v[ACC_W] != v[ACC_W-1]) begin
      r = v[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      r = v[ACC_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat_sample(input acc_t v);
    logic signed [SAMPLE_W-1:0] r;
    if (v[ACC_W-1:SAMPLE_W-1] != {(ACC_W-SAMPLE_W+1){v[ACC_W-1]}}) begin
      r = v[ACC_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [MEM_AW-1:0] mem_index(input stage_t stage, input logic path,
                                                   input sect_t sect);
    logic [MEM_AW-1:0] base;
    base = MEM_AW'({stage, path});
    return MEM_AW'(base * MEM_AW'(SECTIONS) + MEM_AW'(sect));
  endfunction

  function automatic logic [COEF_IW-1:0] coef_index(input logic path, input sect_t sect);
    return path ? COEF_IW'(SECTIONS) + COEF_IW'(sect) : COEF_IW'(sect);
  endfunction

endpackage

// ===== design/hbad_seq.sv =====
module hbad_seq
  import hbad_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        emit_ok_i,
  input  logic [1:0]  stage_count_i,
  output ctrl_t       ctrl_o
);

  step_t                 pc_q, pc_d;
  stage_t                stage_q, stage_d;
  logic                  path_q, path_d;
  logic [MAX_STAGES-1:0] phase_q, phase_d;
  ctrl_word_t            word;
  stage_t                last_stage;

  assign word       = MICRO_ROM[pc_q];
  assign last_stage = STAGE_W'(stage_count_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q    <= STEP_IDLE;
      stage_q <= '0;
      path_q  <= 1'b0;
      phase_q <= '0;
    end else begin
      pc_q    <= pc_d;
      stage_q <= stage_d;
      path_q  <= path_d;
      phase_q <= phase_d;
    end
  end

  always_comb begin
    pc_d    = pc_q + 1'b1;
    stage_d = stage_q;
    path_d  = path_q;
    phase_d = phase_q;
    unique case (word.op)
      OP_IDLE: begin
        pc_d    = start_i ? pc_q + 1'b1 : STEP_IDLE;
        stage_d = '0;
      end
      OP_DISPATCH: begin
        if (stage_q == last_stage) begin
          pc_d = word.jmp;
        end else begin
          path_d = phase_q[stage_q];
        end
      end
      OP_MUL_IN, OP_ADD_MEM, OP_MUL_OUT, OP_SUB_MEM: begin
        pc_d = pc_q + 1'b1;
      end
      OP_COMBINE: begin
        phase_d[stage_q] = ~path_q;
        if (path_q) begin
          stage_d = stage_q + 1'b1;
          pc_d    = word.jmp;
        end else begin
          pc_d = STEP_IDLE;
        end
      end
      OP_EMIT: begin
        pc_d = emit_ok_i ? word.jmp : pc_q;
      end
      default: pc_d = STEP_IDLE;
    endcase
  end

  assign ctrl_o = '{op: word.op, sect: word.sect, stage: stage_q, path: path_q};

endmodule

// ===== design/halfband_allpass_decimator.sv =====
// Half-band allpass decimator, 0 to 3 halving stages (stage_count), one 24-bit sample per
// transaction, one result per 2^stage_count inputs. One item at a time: in_ready_o is high
// only while idle. A microcoded sequencer drives a single 18x28 multiplier; each allpass
// section is two products, an add and a subtract, so each stage an item passes runs a
// dispatch step, the three sections and a combine step. An item stops in a stage on an
// even phase and otherwise goes on; one that completes all stage_count stages yields a
// result. The output is registered, so a new sample is taken while a result waits.
// Configuration writes are always accepted and must only be issued while idle.
module halfband_allpass_decimator
  import hbad_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [SAMPLE_W-1:0] sample_in_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [SAMPLE_W-1:0] sample_out_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  cfg_index_t                 cfg_index_i,
  input  logic [COEF_W-1:0]          cfg_data_i
);

  ctrl_t                      ctrl;
  logic                       start;
  logic                       emit_ok;
  logic [1:0]                 stage_count_q;
  logic [COEF_W-1:0]          coef_q [NUM_COEFS];
  acc_t                       mem_q [MEM_DEPTH];
  acc_t                       delay_q [MAX_STAGES];
  acc_t                       hold_q [MAX_STAGES];
  acc_t                       x_q, x_d;
  acc_t                       t_q, t_d;
  acc_t                       prod_q, prod_d;
  logic signed [SAMPLE_W-1:0] out_q, out_d;
  logic                       out_valid_q, out_valid_d;
  logic [MEM_AW-1:0]          midx;
  logic [COEF_W-1:0]          coef_sel;
  acc_t                       mul_op;
  logic signed [PROD_W-1:0]   prod_full;
  logic signed [PROD_W-1:0]   prod_rnd;
  acc_t                       mem_new;
  logic signed [ACC_W:0]      comb_sum;

  assign start       = in_valid_i && in_ready_o;
  assign emit_ok     = !out_valid_q || out_ready_i;
  assign in_ready_o  = (ctrl.op == OP_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign sample_out_o = out_q;

  hbad_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .emit_ok_i    (emit_ok),
    .stage_count_i(stage_count_q),
    .ctrl_o       (ctrl)
  );

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_count_q <= 2'd1;
      for (int i = 0; i < NUM_COEFS; i++) coef_q[i] <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_STAGE_COUNT:    stage_count_q <= cfg_data_i[1:0];
        REG_DIRECT_COEF_A:  coef_q[0] <= cfg_data_i;
        REG_DIRECT_COEF_B:  coef_q[1] <= cfg_data_i;
        REG_DIRECT_COEF_C:  coef_q[2] <= cfg_data_i;
        REG_DELAYED_COEF_A: coef_q[3] <= cfg_data_i;
        REG_DELAYED_COEF_B: coef_q[4] <= cfg_data_i;
        REG_DELAYED_COEF_C: coef_q[5] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign midx      = mem_index(ctrl.stage, ctrl.path, ctrl.sect);
  assign coef_sel  = coef_q[coef_index(ctrl.path, ctrl.sect)];
  assign mul_op    = (ctrl.op == OP_MUL_OUT) ? t_q : x_q;
  assign prod_full = $signed({1'b0, coef_sel}) * mul_op;
  assign prod_rnd  = prod_full + (PROD_W'(1) <<< (COEF_W - 1));
  assign mem_new   = sat_acc((ACC_W+1)'(x_q) - (ACC_W+1)'(prod_q));
  assign comb_sum  = (ACC_W+1)'(hold_q[ctrl.stage]) + (ACC_W+1)'(delay_q[ctrl.stage])
                     + (ACC_W+1)'(1);

  always_comb begin
    x_d         = x_q;
    t_d         = t_q;
    prod_d      = prod_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (ctrl.op)
      OP_IDLE: begin
        if (start) x_d = ACC_W'(sample_in_i);
      end
      OP_MUL_IN, OP_MUL_OUT: begin
        prod_d = sat_acc(prod_rnd[PROD_W-1:COEF_W]);
      end
      OP_ADD_MEM: begin
        t_d = sat_acc((ACC_W+1)'(prod_q) + (ACC_W+1)'(mem_q[midx]));
      end
      OP_SUB_MEM: begin
        x_d = t_q;
      end
      OP_COMBINE: begin
        if (ctrl.path) x_d = comb_sum[ACC_W:1];
      end
      OP_EMIT: begin
        if (emit_ok) begin
          out_d       = sat_sample(x_q);
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    t_q    <= t_d;
    prod_q <= prod_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MEM_DEPTH; i++) mem_q[i] <= '0;
      for (int i = 0; i < MAX_STAGES; i++) begin
        delay_q[i] <= '0;
        hold_q[i]  <= '0;
      end
    end else begin
      if (ctrl.op == OP_SUB_MEM) mem_q[midx] <= mem_new;
      if (ctrl.op == OP_COMBINE) begin
        if (ctrl.path) begin
          delay_q[ctrl.stage] <= x_q;
        end else begin
          hold_q[ctrl.stage] <= x_q;
        end
      end
    end
  end

endmodule

// ===== design/hbad_checker.sv =====
module hbad_checker
  import hbad_pkg::*;
(
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic signed [SAMPLE_W-1:0] sample_in_i,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic signed [SAMPLE_W-1:0] sample_out_o
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(sample_out_o))
    else $error("result dropped or changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("second sample taken while one is in flight");

  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !$rose(out_valid_o))
    else $error("result appeared without any processing");

  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result raised without a sample in flight");

endmodule

bind halfband_allpass_decimator hbad_checker u_hbad_checker (.*);
